>>> design/ltlm_pkg.sv
`timescale 1ns / 1ps
package ltlm_pkg;

    // Event codes carried in the operation field.
    localparam logic [1:0] OP_REPLY   = 2'd0;
    localparam logic [1:0] OP_REQUEST = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_WARMUP   = 2'd0;
    localparam logic [1:0] REG_WINDOW_F = 2'd1;
    localparam logic [1:0] REG_WINDOW_S = 2'd2;
    localparam logic [1:0] REG_STALE    = 2'd3;

    localparam logic [7:0]  METER_MAGIC      = 8'hE7;
    localparam logic [7:0]  KIND_TIMED       = 8'd1;
    localparam logic [6:0]  LOSS_CLAMP       = 7'd99;
    localparam logic [7:0]  WARMUP_RESET     = 8'd30;
    localparam logic [15:0] WINDOW_F_RESET   = 16'd240;
    localparam logic [3:0]  WINDOW_S_RESET   = 4'd4;
    localparam logic [15:0] STALE_RESET      = 16'd30;
    localparam int          DIV_W            = 23;

    // Request to the shared serial divider.
    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [15:0]       divisor;
    } div_req_t;

    // Status of the shared serial divider.
    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_W-1:0]  quotient;
    } div_rsp_t;

endpackage

>>> design/ltlm_divider.sv
`timescale 1ns / 1ps
module ltlm_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  ltlm_pkg::div_req_t req,
    output ltlm_pkg::div_rsp_t rsp
);
    import ltlm_pkg::*;

    logic [DIV_W-1:0] quot_reg, quot_next;
    logic [16:0]      rem_reg, rem_next;
    logic [15:0]      den_reg, den_next;
    logic [4:0]       count_reg, count_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [16:0]      trial;

    // One quotient bit per cycle by restoring division.
    always_comb
    begin
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        trial      = {rem_reg[15:0], quot_reg[DIV_W-1]};
        if (req.start)
        begin
            quot_next  = req.dividend;
            rem_next   = '0;
            den_next   = req.divisor;
            count_next = 5'(DIV_W);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next  = trial - {1'b0, den_reg};
                quot_next = {quot_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                quot_next = {quot_reg[DIV_W-2:0], 1'b0};
            end
            count_next = count_reg - 5'd1;
            if (count_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;
endmodule

>>> design/link_timing_loss_meter.sv
`timescale 1ns / 1ps
// A result is offered in S_OUT, reached from S_TIME1, or via S_TIME2 for a timed reply
// after warmup. A tick that closes a window runs up to five divisions on the shared serial
// divider through S_WIN, S_DIV and S_DIVWAIT; a loss division is skipped for an empty or
// loss-free window. One transaction at a time; in_ready is low until the result is taken,
// so a new one is not accepted before the last is through. Reset (rst_n, asynchronous,
// active low) clears counters and results; warmup reloads, stale is set, best loss is 99.
module link_timing_loss_meter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic        link_active,
    input  logic [7:0]  magic_byte,
    input  logic [7:0]  packet_kind,
    input  logic [15:0] peer_sequence,
    input  logic [15:0] send_time,
    input  logic [15:0] peer_receive_time,
    input  logic [15:0] peer_transmit_time,
    input  logic [15:0] time_now,
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [15:0] delay,
    output logic signed [15:0] offset,
    output logic signed [15:0] jitter,
    output logic        delay_valid,
    output logic        stale,
    output logic [15:0] tx_rate,
    output logic [15:0] rx_rate,
    output logic [6:0]  loss_round_trip,
    output logic [6:0]  loss_forward,
    output logic [6:0]  loss_reverse,
    output logic [6:0]  loss_worst,
    output logic [6:0]  loss_best,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import ltlm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_TIME1, S_TIME2, S_WIN, S_DIV, S_DIVWAIT, S_OUT
    } state_t;

    state_t state_reg;

    // Configuration.
    logic [7:0]  warmup_cfg_reg;
    logic [15:0] window_f_reg, stale_cfg_reg;
    logic [3:0]  window_s_reg;

    // Captured transaction.
    logic [1:0]  op_reg;
    logic        act_reg;
    logic [7:0]  magic_reg, kind_reg;
    logic [15:0] pseq_reg, t1_reg, t2_reg, t3_reg, t4_reg;

    // Meter state.
    logic [15:0] sent_cnt_reg, reply_cnt_reg, last_pseq_reg, last_rtime_reg;
    logic        have_reply_reg, have_delay_reg, win_started_reg, stale_reg;
    logic [7:0]  warm_left_reg;
    logic [15:0] delay_reg, offset_reg, jitter_reg, prev_delay_reg;
    logic [15:0] win_time_reg, win_sent_reg, win_reply_reg, win_peer_reg;
    logic [15:0] sent_rate_reg, reply_rate_reg;
    logic [6:0]  loss_rt_reg, loss_fwd_reg, loss_rev_reg, loss_max_reg, loss_min_reg;

    // Timing scratch and window deltas.
    logic [15:0] dly_reg, off_reg;
    logic [15:0] d_tx_reg, d_got_reg, d_ps_reg;
    logic [2:0]  div_step_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    ltlm_divider u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

    // Combinational helpers for the timing path.
    logic [15:0] dly_c, off_c, jd_c, inst_c;
    logic [16:0] off_ext_c, jdiff_c;
    always_comb
    begin
        dly_c     = (t4_reg - t1_reg) - (t3_reg - t2_reg);
        off_ext_c = 17'($signed({(16'(t2_reg - t1_reg)) >> 15 != 0, 16'(t2_reg - t1_reg)}))
                  + 17'($signed({(16'(t3_reg - t4_reg)) >> 15 != 0, 16'(t3_reg - t4_reg)}));
        // Halve toward zero.
        off_c     = 16'(($signed(off_ext_c) + (off_ext_c[16] ? 17'sd1 : 17'sd0)) >>> 1);
        jd_c      = dly_reg - prev_delay_reg;
        inst_c    = jd_c[15] ? 16'(-jd_c) : jd_c;
        // The jitter step difference needs a seventeenth bit before the shift.
        jdiff_c   = {inst_c[15], inst_c} - {jitter_reg[15], jitter_reg};
    end

    // Divider operand selection per step: two rates, then three losses.
    logic [15:0] secs_c, tot_c, kept_c;
    logic        loss_skip_c;
    always_comb
    begin
        secs_c = (window_s_reg == 4'd0) ? 16'd1 : {12'd0, window_s_reg};
        case (div_step_reg)
            3'd2:    begin tot_c = d_tx_reg; kept_c = d_got_reg; end
            3'd3:    begin tot_c = d_tx_reg; kept_c = d_ps_reg;  end
            default: begin tot_c = d_ps_reg; kept_c = d_got_reg; end
        endcase
        loss_skip_c = (tot_c == 16'd0) || (kept_c >= tot_c);
        div_req.start = (state_reg == S_DIV) && !(div_step_reg >= 3'd2 && loss_skip_c);
        if (div_step_reg < 3'd2)
        begin
            div_req.dividend = {7'd0, (div_step_reg == 3'd0) ? d_tx_reg : d_got_reg};
            div_req.divisor  = secs_c;
        end
        else
        begin
            div_req.dividend = 23'(tot_c - kept_c) * 23'd100;
            div_req.divisor  = tot_c;
        end
    end

    logic [6:0] loss_q_c;
    assign loss_q_c = (div_rsp.quotient > 23'd99) ? LOSS_CLAMP : div_rsp.quotient[6:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            warmup_cfg_reg <= WARMUP_RESET;
            window_f_reg <= WINDOW_F_RESET;
            window_s_reg <= WINDOW_S_RESET;
            stale_cfg_reg <= STALE_RESET;
            sent_cnt_reg <= '0; reply_cnt_reg <= '0; last_pseq_reg <= '0;
            last_rtime_reg <= '0; have_reply_reg <= 1'b0; have_delay_reg <= 1'b0;
            win_started_reg <= 1'b0; stale_reg <= 1'b1; warm_left_reg <= WARMUP_RESET;
            delay_reg <= '0; offset_reg <= '0; jitter_reg <= '0; prev_delay_reg <= '0;
            win_time_reg <= '0; win_sent_reg <= '0; win_reply_reg <= '0; win_peer_reg <= '0;
            sent_rate_reg <= '0; reply_rate_reg <= '0;
            loss_rt_reg <= '0; loss_fwd_reg <= '0; loss_rev_reg <= '0;
            loss_max_reg <= '0; loss_min_reg <= LOSS_CLAMP;
            div_step_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WARMUP:
                    begin
                        warmup_cfg_reg <= cfg_data[7:0];
                        warm_left_reg  <= cfg_data[7:0];
                    end
                    REG_WINDOW_F: window_f_reg  <= cfg_data;
                    REG_WINDOW_S: window_s_reg  <= cfg_data[3:0];
                    REG_STALE:    stale_cfg_reg <= cfg_data;
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_TIME1;
                    end
                end
                S_TIME1:
                begin
                    state_reg <= S_OUT;
                    if (op_reg == OP_REPLY && act_reg && magic_reg == METER_MAGIC)
                    begin
                        have_reply_reg <= 1'b1;
                        last_rtime_reg <= t4_reg;
                        reply_cnt_reg  <= reply_cnt_reg + 16'd1;
                        last_pseq_reg  <= pseq_reg;
                        if (kind_reg == KIND_TIMED && warm_left_reg == 8'd0)
                        begin
                            dly_reg   <= dly_c;
                            off_reg   <= off_c;
                            state_reg <= S_TIME2;
                        end
                    end
                    else if (op_reg == OP_REQUEST && act_reg)
                    begin
                        sent_cnt_reg <= sent_cnt_reg + 16'd1;
                    end
                    else if (op_reg == OP_TICK)
                    begin
                        stale_reg <= !have_reply_reg
                                  || (16'(t4_reg - last_rtime_reg) > stale_cfg_reg);
                        if (act_reg)
                        begin
                            if (warm_left_reg != 8'd0)
                                warm_left_reg <= warm_left_reg - 8'd1;
                            if (!win_started_reg)
                            begin
                                win_started_reg <= 1'b1;
                                win_time_reg  <= t4_reg;
                                win_sent_reg  <= sent_cnt_reg;
                                win_reply_reg <= reply_cnt_reg;
                                win_peer_reg  <= last_pseq_reg;
                            end
                            else if (16'(t4_reg - win_time_reg) >= window_f_reg)
                            begin
                                state_reg <= S_WIN;
                            end
                        end
                    end
                end
                S_TIME2:
                begin
                    delay_reg      <= dly_reg;
                    offset_reg     <= off_reg;
                    jitter_reg     <= have_delay_reg
                        ? 16'(jitter_reg + 16'($signed(jdiff_c) >>> 2)) : inst_c;
                    prev_delay_reg <= dly_reg;
                    have_delay_reg <= 1'b1;
                    state_reg      <= S_OUT;
                end
                S_WIN:
                begin
                    d_tx_reg  <= sent_cnt_reg - win_sent_reg;
                    d_got_reg <= reply_cnt_reg - win_reply_reg;
                    d_ps_reg  <= last_pseq_reg - win_peer_reg;
                    win_time_reg  <= t4_reg;
                    win_sent_reg  <= sent_cnt_reg;
                    win_reply_reg <= reply_cnt_reg;
                    win_peer_reg  <= last_pseq_reg;
                    div_step_reg  <= 3'd0;
                    state_reg     <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_req.start)
                        state_reg <= S_DIVWAIT;
                    else
                    begin
                        // Loss of an empty or loss-free window is zero.
                        case (div_step_reg)
                            3'd2: loss_rt_reg  <= '0;
                            3'd3: loss_fwd_reg <= '0;
                            default: loss_rev_reg <= '0;
                        endcase
                        if (div_step_reg == 3'd2 && d_tx_reg != 16'd0)
                            loss_min_reg <= '0;
                        if (div_step_reg == 3'd4)
                            state_reg <= S_OUT;
                        div_step_reg <= div_step_reg + 3'd1;
                    end
                end
                S_DIVWAIT:
                begin
                    if (div_rsp.done)
                    begin
                        case (div_step_reg)
                            3'd0: sent_rate_reg  <= div_rsp.quotient[15:0];
                            3'd1: reply_rate_reg <= div_rsp.quotient[15:0];
                            3'd2:
                            begin
                                loss_rt_reg <= loss_q_c;
                                if (loss_q_c > loss_max_reg) loss_max_reg <= loss_q_c;
                                if (loss_q_c < loss_min_reg) loss_min_reg <= loss_q_c;
                            end
                            3'd3: loss_fwd_reg <= loss_q_c;
                            default: loss_rev_reg <= loss_q_c;
                        endcase
                        div_step_reg <= div_step_reg + 3'd1;
                        state_reg <= (div_step_reg == 3'd4) ? S_OUT : S_DIV;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Capture the transaction payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg <= operation; act_reg <= link_active;
            magic_reg <= magic_byte; kind_reg <= packet_kind;
            pseq_reg <= peer_sequence; t1_reg <= send_time;
            t2_reg <= peer_receive_time; t3_reg <= peer_transmit_time;
            t4_reg <= time_now;
        end
    end

    assign in_ready        = (state_reg == S_IDLE);
    assign out_valid       = (state_reg == S_OUT);
    assign delay           = delay_reg;
    assign offset          = offset_reg;
    assign jitter          = jitter_reg;
    assign delay_valid     = have_delay_reg;
    assign stale           = stale_reg;
    assign tx_rate         = sent_rate_reg;
    assign rx_rate         = reply_rate_reg;
    assign loss_round_trip = loss_rt_reg;
    assign loss_forward    = loss_fwd_reg;
    assign loss_reverse    = loss_rev_reg;
    assign loss_worst      = loss_max_reg;
    assign loss_best       = loss_min_reg;

    // The divider only runs during a window close.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.busy |-> (state_reg == S_DIVWAIT))
        else $error("divider busy outside a window close");
    // Round-trip and worst loss never exceed the clamp.
    assert property (@(posedge clk) disable iff (!rst_n)
        (loss_rt_reg <= LOSS_CLAMP) && (loss_max_reg <= LOSS_CLAMP))
        else $error("loss above clamp");
    // A result is never shown while an input is being taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("ready and result overlap");
endmodule

>>> sim/link_timing_loss_meter_tb.sv
`timescale 1ns / 1ps
module link_timing_loss_meter_tb;
    import ltlm_pkg::*;

    typedef struct {
        logic [1:0]  op;
        logic        active;
        logic [7:0]  magic;
        logic [7:0]  kind;
        logic [15:0] pseq;
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [15:0] now;
    } event_t;

    typedef struct {
        logic [15:0] dly;
        logic [15:0] off;
        logic [15:0] jit;
        logic        dvalid;
        logic        stl;
        logic [15:0] txr;
        logic [15:0] rxr;
        logic [6:0]  lrt;
        logic [6:0]  lfwd;
        logic [6:0]  lrev;
        logic [6:0]  lmax;
        logic [6:0]  lmin;
    } status_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  operation = '0;
    logic        link_active = 1'b0;
    logic [7:0]  magic_byte = '0;
    logic [7:0]  packet_kind = '0;
    logic [15:0] peer_sequence = '0;
    logic [15:0] send_time = '0;
    logic [15:0] peer_receive_time = '0;
    logic [15:0] peer_transmit_time = '0;
    logic [15:0] time_now = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic signed [15:0] delay;
    logic signed [15:0] offset;
    logic signed [15:0] jitter;
    logic        delay_valid;
    logic        stale;
    logic [15:0] tx_rate;
    logic [15:0] rx_rate;
    logic [6:0]  loss_round_trip;
    logic [6:0]  loss_forward;
    logic [6:0]  loss_reverse;
    logic [6:0]  loss_worst;
    logic [6:0]  loss_best;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    link_timing_loss_meter dut (.*);

    always #4 clk = ~clk;

    // Meter state mirrored by the predictor.
    logic [7:0]  m_warmup_cfg;
    logic [15:0] m_win_frames;
    logic [3:0]  m_win_secs;
    logic [15:0] m_stale_cfg;
    logic [15:0] m_sent, m_replies, m_peer_seq, m_reply_time;
    logic        m_have_reply;
    logic [7:0]  m_warmup_left;
    logic [15:0] m_delay, m_offset, m_jitter, m_prev_delay;
    logic        m_have_delay, m_win_open;
    logic [15:0] m_win_time, m_win_sent, m_win_replies, m_win_peer;
    logic [15:0] m_tx_rate, m_rx_rate;
    logic [6:0]  m_loss_rt, m_loss_fwd, m_loss_rev, m_loss_max, m_loss_min;
    logic        m_stale;

    event_t  pending_events[$];
    status_t expected_status[$];
    event_t  cur;
    int      errors = 0;
    int      cycles = 0;
    logic    quiet = 1'b0;
    logic    hold_go = 1'b0;
    logic    hold_done = 1'b0;
    int      hold_cnt = 0;
    int      tx_gap = 0;
    int      rx_burst = 0;
    logic [15:0] gen_time = 16'd100;
    logic [15:0] gen_peer = 16'd0;

    function automatic logic [6:0] loss_pct(input logic [15:0] total, input logic [15:0] kept);
        int p;
        if (total == 0 || kept >= total)
            return 7'd0;
        p = (int'(total - kept) * 100) / int'(total);
        return (p > 99) ? LOSS_CLAMP : 7'(p);
    endfunction

    task automatic model_reset();
        m_warmup_cfg = WARMUP_RESET;
        m_win_frames = WINDOW_F_RESET;
        m_win_secs = WINDOW_S_RESET;
        m_stale_cfg = STALE_RESET;
        {m_sent, m_replies, m_peer_seq, m_reply_time} = '0;
        m_have_reply = 1'b0;
        m_warmup_left = WARMUP_RESET;
        {m_delay, m_offset, m_jitter, m_prev_delay} = '0;
        m_have_delay = 1'b0;
        m_win_open = 1'b0;
        {m_win_time, m_win_sent, m_win_replies, m_win_peer} = '0;
        m_tx_rate = '0;
        m_rx_rate = '0;
        {m_loss_rt, m_loss_fwd, m_loss_rev, m_loss_max} = '0;
        m_loss_min = LOSS_CLAMP;
        m_stale = 1'b1;
    endtask

    task automatic window_tick(input logic [15:0] now);
        logic [15:0] d_tx, d_got, d_ps;
        int secs;
        if (!m_win_open) begin
            m_win_open = 1'b1;
        end else begin
            if (16'(now - m_win_time) < m_win_frames)
                return;
            d_tx = m_sent - m_win_sent;
            d_got = m_replies - m_win_replies;
            d_ps = m_peer_seq - m_win_peer;
            secs = (m_win_secs == 0) ? 1 : int'(m_win_secs);
            m_tx_rate = 16'(int'(d_tx) / secs);
            m_rx_rate = 16'(int'(d_got) / secs);
            m_loss_rt = loss_pct(d_tx, d_got);
            m_loss_fwd = loss_pct(d_tx, d_ps);
            m_loss_rev = loss_pct(d_ps, d_got);
            if (d_tx > 0) begin
                if (m_loss_rt > m_loss_max) m_loss_max = m_loss_rt;
                if (m_loss_rt < m_loss_min) m_loss_min = m_loss_rt;
            end
        end
        m_win_time = now;
        m_win_sent = m_sent;
        m_win_replies = m_replies;
        m_win_peer = m_peer_seq;
    endtask

    task automatic reply_timing(input event_t ev);
        logic [15:0] dly, off, d, inst;
        int sum;
        dly = (ev.now - ev.t1) - (ev.t3 - ev.t2);
        sum = int'($signed(16'(ev.t2 - ev.t1))) + int'($signed(16'(ev.t3 - ev.now)));
        off = 16'(sum / 2);
        if (m_warmup_left != 0)
            return;
        m_delay = dly;
        m_offset = off;
        d = dly - m_prev_delay;
        inst = d[15] ? 16'(-int'($signed(d))) : d;
        if (m_have_delay)
            m_jitter = 16'(int'($signed(m_jitter))
                     + ((int'($signed(inst)) - int'($signed(m_jitter))) >>> 2));
        else
            m_jitter = inst;
        m_prev_delay = dly;
        m_have_delay = 1'b1;
    endtask

    // Advance the mirrored meter by one event and return the status it reports.
    task automatic meter_step(input event_t ev, output status_t st);
        if (ev.op == OP_REPLY && ev.active) begin
            if (ev.magic == METER_MAGIC) begin
                m_have_reply = 1'b1;
                m_reply_time = ev.now;
                m_replies = m_replies + 16'd1;
                m_peer_seq = ev.pseq;
                if (ev.kind == KIND_TIMED)
                    reply_timing(ev);
            end
        end else if (ev.op == OP_REQUEST && ev.active) begin
            m_sent = m_sent + 16'd1;
        end else if (ev.op == OP_TICK) begin
            if (ev.active) begin
                if (m_warmup_left > 0) m_warmup_left = m_warmup_left - 8'd1;
                window_tick(ev.now);
            end
            m_stale = !m_have_reply || (16'(ev.now - m_reply_time) > m_stale_cfg);
        end
        st = '{m_delay, m_offset, m_jitter, m_have_delay, m_stale, m_tx_rate, m_rx_rate,
               m_loss_rt, m_loss_fwd, m_loss_rev, m_loss_max, m_loss_min};
    endtask

    // Sender: one transaction offered at a time, held until accepted.
    always @(posedge clk) begin
        status_t st;
        if (in_valid && in_ready) begin
            meter_step(cur, st);
            expected_status.push_back(st);
        end
        if (!(in_valid && !in_ready)) begin
            if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                in_valid <= 1'b0;
            end else if (pending_events.size() > 0) begin
                cur = pending_events.pop_front();
                operation <= cur.op;
                link_active <= cur.active;
                magic_byte <= cur.magic;
                packet_kind <= cur.kind;
                peer_sequence <= cur.pseq;
                send_time <= cur.t1;
                peer_receive_time <= cur.t2;
                peer_transmit_time <= cur.t3;
                time_now <= cur.now;
                in_valid <= 1'b1;
                if (!quiet && $urandom_range(0, 7) == 0)
                    tx_gap <= $urandom_range(1, 15);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random ready bursts, plus one long hold-off.
    always @(posedge clk) begin
        if (hold_go && !hold_done) begin
            hold_done <= 1'b1;
            hold_cnt <= 400;
            out_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            out_ready <= 1'b0;
        end else if (quiet) begin
            out_ready <= 1'b1;
        end else if (rx_burst > 0) begin
            rx_burst <= rx_burst - 1;
        end else begin
            out_ready <= ($urandom_range(0, 2) != 0);
            rx_burst <= $urandom_range(1, 15);
        end
    end

    // Compare each result transaction with the oldest expected status.
    always @(posedge clk) begin
        status_t e;
        status_t a;
        if (out_valid && out_ready) begin
            a = '{delay, offset, jitter, delay_valid, stale, tx_rate, rx_rate,
                  loss_round_trip, loss_forward, loss_reverse, loss_worst, loss_best};
            if (expected_status.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result transaction at cycle %0d", cycles);
            end else begin
                e = expected_status.pop_front();
                if (a != e) begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch cycle %0d: exp dly %h off %h jit %h dv %b st %b ",
                                  "tx %h rx %h loss %0d/%0d/%0d worst %0d best %0d; got dly %h ",
                                  "off %h jit %h dv %b st %b tx %h rx %h loss %0d/%0d/%0d ",
                                  "worst %0d best %0d"}, cycles,
                                 e.dly, e.off, e.jit, e.dvalid, e.stl, e.txr, e.rxr,
                                 e.lrt, e.lfwd, e.lrev, e.lmax, e.lmin,
                                 a.dly, a.off, a.jit, a.dvalid, a.stl, a.txr, a.rxr,
                                 a.lrt, a.lfwd, a.lrev, a.lmax, a.lmin);
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic event_t make_event(input logic [1:0] op, input logic act,
                                          input logic [7:0] mg, input logic [7:0] kd,
                                          input logic [15:0] ps, input logic [15:0] a,
                                          input logic [15:0] b, input logic [15:0] c,
                                          input logic [15:0] n);
        event_t ev;
        ev = '{op, act, mg, kd, ps, a, b, c, n};
        return ev;
    endfunction

    // Mostly coherent traffic with random timing; some pure noise.
    function automatic event_t random_event();
        event_t ev;
        int sel;
        logic [15:0] t1, t2, t3;
        if ($urandom_range(0, 99) < 12) begin
            ev = make_event(2'($urandom), 1'($urandom), 8'($urandom), 8'($urandom),
                            16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom));
            return ev;
        end
        sel = $urandom_range(0, 9);
        if (sel < 4) begin
            gen_time = ($urandom_range(0, 19) == 0) ? 16'($urandom) : gen_time + 16'd1;
            ev = make_event(OP_TICK, $urandom_range(0, 19) != 0, 8'h0, 8'h0, 16'h0,
                            16'h0, 16'h0, 16'h0, gen_time);
        end else if (sel < 7) begin
            ev = make_event(OP_REQUEST, $urandom_range(0, 19) != 0, 8'($urandom),
                            8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom), gen_time);
        end else begin
            gen_peer = gen_peer
                     + 16'(($urandom_range(0, 4) == 0) ? $urandom_range(2, 4) : 1);
            t1 = gen_time - 16'($urandom_range(0, 20));
            t2 = t1 + 16'($urandom_range(0, 600)) - 16'd300;
            t3 = t2 + 16'($urandom_range(0, 3));
            ev = make_event(OP_REPLY, $urandom_range(0, 19) != 0,
                            ($urandom_range(0, 19) == 0) ? 8'($urandom) : METER_MAGIC,
                            ($urandom_range(0, 4) == 0) ? 8'($urandom) : KIND_TIMED,
                            gen_peer, t1, t2, t3, gen_time);
        end
        return ev;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_WARMUP: begin
                m_warmup_cfg = val[7:0];
                m_warmup_left = val[7:0];
            end
            REG_WINDOW_F: m_win_frames = val;
            REG_WINDOW_S: m_win_secs = val[3:0];
            default: m_stale_cfg = val;
        endcase
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_events.size() > 0 || in_valid || expected_status.size() > 0);
        repeat (10) @(posedge clk);
    endtask

    task automatic run_phase(input logic [7:0] wu, input logic [15:0] wf,
                             input logic [3:0] ws, input logic [15:0] sf, input int count);
        wait_drained();
        write_reg(REG_WARMUP, {8'h0, wu});
        write_reg(REG_WINDOW_F, wf);
        write_reg(REG_WINDOW_S, {12'h0, ws});
        write_reg(REG_STALE, sf);
        repeat (count) pending_events.push_back(random_event());
    endtask

    initial begin
        model_reset();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: special cases and field extremes with timing enabled.
        write_reg(REG_WARMUP, 16'd0);
        pending_events.push_back(make_event(OP_TICK, 1'b1, 8'h00, 8'h00, 16'h0, 16'h0,
                                            16'h0, 16'h0, 16'h0000));
        pending_events.push_back(make_event(OP_REPLY, 1'b1, 8'h00, 8'h01, 16'hFFFF,
                                            16'h1, 16'h2, 16'h3, 16'h4));
        pending_events.push_back(make_event(OP_REPLY, 1'b1, 8'hFF, 8'h01, 16'h5,
                                            16'h1, 16'h2, 16'h3, 16'h4));
        pending_events.push_back(make_event(OP_REPLY, 1'b0, METER_MAGIC, KIND_TIMED,
                                            16'h7, 16'h1, 16'h2, 16'h3, 16'h9));
        pending_events.push_back(make_event(2'd3, 1'b1, METER_MAGIC, KIND_TIMED,
                                            16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        pending_events.push_back(make_event(OP_REQUEST, 1'b0, 8'h0, 8'h0, 16'h0, 16'h0,
                                            16'h0, 16'h0, 16'h0));
        repeat (3)
            pending_events.push_back(make_event(OP_REQUEST, 1'b1, 8'hFF, 8'hFF, 16'hFFFF,
                                                16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        pending_events.push_back(make_event(OP_REPLY, 1'b1, METER_MAGIC, 8'h00, 16'h1,
                                            16'h0, 16'h0, 16'h0, 16'h2));
        pending_events.push_back(make_event(OP_REPLY, 1'b1, METER_MAGIC, KIND_TIMED, 16'h2,
                                            16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF));
        pending_events.push_back(make_event(OP_REPLY, 1'b1, METER_MAGIC, KIND_TIMED, 16'h3,
                                            16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF));
        pending_events.push_back(make_event(OP_REPLY, 1'b1, METER_MAGIC, KIND_TIMED, 16'h4,
                                            16'h8000, 16'h0000, 16'hFFFF, 16'h7FFF));
        pending_events.push_back(make_event(OP_REPLY, 1'b1, METER_MAGIC, KIND_TIMED, 16'h5,
                                            16'h0010, 16'h0013, 16'h0014, 16'h0020));
        pending_events.push_back(make_event(OP_TICK, 1'b0, 8'h0, 8'h0, 16'h0, 16'h0,
                                            16'h0, 16'h0, 16'h0100));
        pending_events.push_back(make_event(OP_TICK, 1'b1, 8'h0, 8'h0, 16'h0, 16'h0,
                                            16'h0, 16'h0, 16'h0021));
        pending_events.push_back(make_event(OP_TICK, 1'b1, 8'h0, 8'h0, 16'h0, 16'h0,
                                            16'h0, 16'h0, 16'hFFFF));
        pending_events.push_back(make_event(OP_TICK, 1'b1, 8'h0, 8'h0, 16'h0, 16'h0,
                                            16'h0, 16'h0, 16'h0300));

        // Random phases over several settings, extremes among them.
        run_phase(8'd0, 16'd10, 4'd1, 16'd5, 225);
        run_phase(8'd3, 16'd0, 4'd0, 16'd0, 110);
        hold_go = 1'b1;
        repeat (110) pending_events.push_back(random_event());
        run_phase(8'd255, 16'd65535, 4'd15, 16'd65535, 225);
        run_phase(8'd1, 16'd25, 4'd15, 16'd100, 225);
        wait_drained();
        quiet = 1'b1;
        run_phase(8'd0, 16'd1, 4'd4, 16'd30, 225);

        wait_drained();
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
